### design/mlst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table package
// Shared widths, register indexes, action codes and word types.
// ----------------------------------------------------------------------------
package mlst_pkg;

  localparam int MAC_W     = 48;
  localparam int VID_W     = 12;
  localparam int PORT_W    = 32;
  localparam int KEY_W     = 1 + VID_W + MAC_W;  // untagged flag, VLAN, MAC
  localparam int ENTRY_W   = KEY_W + PORT_W;
  localparam int IG_BIT    = 40;                 // low bit of first octet
  localparam int CFG_IDX_W = 1;

  localparam logic [MAC_W-1:0] RESERVED_A_RST = 48'h0180_C200_0000;
  localparam logic [MAC_W-1:0] RESERVED_B_RST = 48'h0100_5E00_00FB;

  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_A = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RESERVED_B = 1'd1;

  typedef enum logic [2:0] {
    ACT_BAD_SRC   = 3'd0,
    ACT_BLOCK     = 3'd1,
    ACT_FLOOD     = 3'd2,
    ACT_FORWARD   = 3'd3,
    ACT_SAME_PORT = 3'd4
  } action_e;

  typedef struct packed {
    logic [MAC_W-1:0]  src_mac;
    logic [MAC_W-1:0]  dst_mac;
    logic              vlan_tagged;
    logic [VID_W-1:0]  vlan_id;
    logic [PORT_W-1:0] in_port;
  } req_t;

  typedef struct packed {
    action_e           action;
    logic [PORT_W-1:0] egress_port;
    logic              learned;
    logic              table_full;
  } rsp_t;

endpackage

### design/mlst_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table stream interface
// Valid/ready channel carrying one word of type T.
// ----------------------------------------------------------------------------
interface mlst_stream_if #(
  parameter type T = logic
) ();

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

### design/mac_learning_switch_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning switch table
// Forwarding decision and source learning over a (VLAN, MAC) keyed table.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries one frame event word (source/destination MAC, VLAN tag
//   state, VLAN id, ingress port). rsp_o returns one decision word per event:
//   action, egress port, learned and table_full flags.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the two reserved destination MACs;
//   write them only while the block is idle.
// Processing:
//   Bad-source and reserved-destination words skip the scan and the decision
//   and go to the output register. All others scan the N filled slots (N at
//   most TABLE_DEPTH), reading one slot at a time from the single RAM read
//   port, then compare the last read data, leave the scan, make the decision
//   and write-back, and pass into the output register.
//   One word is in the engine at a time.
// Reset:
//   The fill count clears, so the table reads as empty at once; no clearing
//   pass. Reserved MACs return to 01:80:c2:00:00:00 and 01:00:5e:00:00:fb.
// Stall:
//   A finished decision waits in the output register; the engine can take
//   and process the next word meanwhile, and holds its own result until the
//   output register frees up.
// ----------------------------------------------------------------------------
module mac_learning_switch_table #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  mlst_stream_if.sink                         req_i,
  mlst_stream_if.source                       rsp_o,
  input  logic                                cfg_we_i,
  input  logic [mlst_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [mlst_pkg::MAC_W-1:0]          cfg_data_i
);

  import mlst_pkg::*;

  // Reserved destination registers
  logic [MAC_W-1:0] rsv_a_q, rsv_a_d;
  logic [MAC_W-1:0] rsv_b_q, rsv_b_d;

  // Engine result and output register
  logic res_valid;
  logic res_ready;
  rsp_t res;
  logic out_valid_q, out_valid_d;
  rsp_t out_data_q, out_data_d;

  always_comb begin
    rsv_a_d = rsv_a_q;
    rsv_b_d = rsv_b_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RESERVED_A: rsv_a_d = cfg_data_i;
        CFG_RESERVED_B: rsv_b_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output stage takes a new result when empty or being drained.
  assign res_ready = !out_valid_q || rsp_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = res;
    end else if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsv_a_q     <= RESERVED_A_RST;
      rsv_b_q     <= RESERVED_B_RST;
      out_valid_q <= 1'b0;
    end else begin
      rsv_a_q     <= rsv_a_d;
      rsv_b_q     <= rsv_b_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  mlst_engine #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .req_i       (req_i.data),
    .rsv_a_i     (rsv_a_q),
    .rsv_b_i     (rsv_b_q),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign rsp_o.valid = out_valid_q;
  assign rsp_o.data  = out_data_q;

endmodule

### design/mlst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table RAM
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mlst_ram #(
  parameter int WIDTH = 93,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/mlst_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table lookup engine
// Linear scan of the filled slots, then decision and learn write-back.
// ----------------------------------------------------------------------------
module mlst_engine #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 req_valid_i,
  output logic                 req_ready_o,
  input  mlst_pkg::req_t       req_i,
  input  logic [47:0]          rsv_a_i,
  input  logic [47:0]          rsv_b_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output mlst_pkg::rsp_t       res_o
);

  import mlst_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_DECIDE = 4'b0100,
    ST_DONE   = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  logic [KEY_W-1:0]  skey_q, skey_d;
  logic [KEY_W-1:0]  dkey_q, dkey_d;
  logic              dst_mc_q, dst_mc_d;
  logic [PORT_W-1:0] in_port_q, in_port_d;
  logic [CW-1:0]     addr_q, addr_d;
  logic              pend_q, pend_d;
  logic [AW-1:0]     pidx_q, pidx_d;
  logic              dst_hit_q, dst_hit_d;
  logic [PORT_W-1:0] dst_port_q, dst_port_d;
  logic              src_hit_q, src_hit_d;
  logic [AW-1:0]     src_idx_q, src_idx_d;
  logic [CW-1:0]     fill_q, fill_d;
  rsp_t              res_q, res_d;

  logic               issue;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] rd_entry;
  logic [KEY_W-1:0]   rd_key;
  logic [PORT_W-1:0]  rd_port;
  logic [KEY_W-1:0]   vkey;
  logic               room;
  action_e            act;

  // Untagged frames use the flag bit with a zero VLAN field.
  assign vkey = {~req_i.vlan_tagged,
                 req_i.vlan_tagged ? req_i.vlan_id : {VID_W{1'b0}},
                 {MAC_W{1'b0}}};

  assign issue   = (state_q == ST_SCAN) && (addr_q < fill_q);
  assign rd_key  = rd_entry[ENTRY_W-1:PORT_W];
  assign rd_port = rd_entry[PORT_W-1:0];
  assign room    = fill_q < CW'(TABLE_DEPTH);

  assign act = !dst_hit_q ? ACT_FLOOD :
               (dst_port_q == in_port_q) ? ACT_SAME_PORT : ACT_FORWARD;

  assign ram_we    = (state_q == ST_DECIDE) && (act != ACT_SAME_PORT) &&
                     (src_hit_q || room);
  assign ram_waddr = src_hit_q ? src_idx_q : fill_q[AW-1:0];

  always_comb begin
    state_d    = state_q;
    skey_d     = skey_q;
    dkey_d     = dkey_q;
    dst_mc_d   = dst_mc_q;
    in_port_d  = in_port_q;
    addr_d     = addr_q;
    pend_d     = 1'b0;
    pidx_d     = addr_q[AW-1:0];
    dst_hit_d  = dst_hit_q;
    dst_port_d = dst_port_q;
    src_hit_d  = src_hit_q;
    src_idx_d  = src_idx_q;
    fill_d     = fill_q;
    res_d      = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_valid_i) begin
          skey_d     = vkey | {{(KEY_W-MAC_W){1'b0}}, req_i.src_mac};
          dkey_d     = vkey | {{(KEY_W-MAC_W){1'b0}}, req_i.dst_mac};
          dst_mc_d   = req_i.dst_mac[IG_BIT];
          in_port_d  = req_i.in_port;
          addr_d     = '0;
          dst_hit_d  = 1'b0;
          src_hit_d  = 1'b0;
          res_d      = '{action: ACT_BAD_SRC, egress_port: '0, learned: 1'b0,
                         table_full: 1'b0};
          priority if (req_i.src_mac[IG_BIT]) begin
            state_d = ST_DONE;
          end else if (req_i.dst_mac == rsv_a_i || req_i.dst_mac == rsv_b_i) begin
            res_d.action = ACT_BLOCK;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        pend_d = issue;
        if (issue) begin
          addr_d = addr_q + 1'b1;
        end
        if (pend_q) begin
          if (!dst_mc_q && !dst_hit_q && rd_key == dkey_q) begin
            dst_hit_d  = 1'b1;
            dst_port_d = rd_port;
          end
          if (!src_hit_q && rd_key == skey_q) begin
            src_hit_d = 1'b1;
            src_idx_d = pidx_q;
          end
        end
        if (!issue && !pend_q) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_d.action      = act;
        res_d.egress_port = (act == ACT_FORWARD) ? dst_port_q : '0;
        res_d.learned     = ram_we;
        res_d.table_full  = (act != ACT_SAME_PORT) && !src_hit_q && !room;
        if (ram_we && !src_hit_q) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    skey_q     <= skey_d;
    dkey_q     <= dkey_d;
    dst_mc_q   <= dst_mc_d;
    in_port_q  <= in_port_d;
    addr_q     <= addr_d;
    pidx_q     <= pidx_d;
    dst_hit_q  <= dst_hit_d;
    dst_port_q <= dst_port_d;
    src_hit_q  <= src_hit_d;
    src_idx_q  <= src_idx_d;
    res_q      <= res_d;
  end

  mlst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({skey_q, in_port_q}),
    .re_i    (issue),
    .raddr_i (addr_q[AW-1:0]),
    .rdata_o (rd_entry)
  );

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;

endmodule

### design/mlst_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MAC learning table port checker
// Port-level properties of the decision stream, bound to the top level.
// ----------------------------------------------------------------------------
module mlst_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          req_valid_i,
  input logic                          req_ready_i,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input mlst_pkg::action_e             action_i,
  input logic [mlst_pkg::PORT_W-1:0]   egress_port_i,
  input logic                          learned_i,
  input logic                          table_full_i
);

  import mlst_pkg::*;

  // A stalled decision word holds.
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(action_i) &&
    $stable(egress_port_i) && $stable(learned_i) && $stable(table_full_i))
    else $error("decision word changed while stalled");

  // Egress port only reported on forward.
  a_port_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && action_i != ACT_FORWARD |-> egress_port_i == '0)
    else $error("egress_port set on non-forward action");

  // Drops and blocks never touch the table.
  a_no_learn_on_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (action_i == ACT_BAD_SRC || action_i == ACT_BLOCK ||
    action_i == ACT_SAME_PORT) |-> !learned_i && !table_full_i)
    else $error("learn flags set on drop action");

  a_learn_full_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> !(learned_i && table_full_i))
    else $error("learned and table_full both set");

  // One event in the engine at a time.
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken on back-to-back cycles");

endmodule

bind mac_learning_switch_table mlst_checker u_mlst_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .action_i      (rsp_o.data.action),
  .egress_port_i (rsp_o.data.egress_port),
  .learned_i     (rsp_o.data.learned),
  .table_full_i  (rsp_o.data.table_full)
);
